[rtl/dtt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the deadline timer table
// Beat layouts of the command and result channels, operation codes, result
// kinds and the sequencer states.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int TIME_W = 32;
    localparam int ID_W   = 4;
    localparam int LEFT_W = 31;
    localparam int WIN_W  = 16;

    localparam logic [WIN_W-1:0] LAZY_WINDOW_RST = 16'd300;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_EXPIRE = 2'd2,
        FUNC_FIND   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_FIND  = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_LAZY,
        S_SCAN,
        S_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [ID_W-1:0]    event_id;
        logic [TIME_W-1:0]  delay;
        logic [TIME_W-1:0]  now_msec;
        logic               cancelable;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    fired_id;
        logic [LEFT_W-1:0]  time_left;
        logic               infinite;
        logic               noncancel_pending;
        logic               last;
    } t_res;

endpackage

[rtl/dtt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dtt_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_alu: shared 32-bit adder/subtractor
// Forms deadlines and every wrap-around time difference of the sequencer.
// ----------------------------------------------------------------------------
module dtt_alu (
    input  dtt_pkg::t_alu_op             i_op,
    input  logic [dtt_pkg::TIME_W-1:0]   i_a,
    input  logic [dtt_pkg::TIME_W-1:0]   i_b,
    output logic [dtt_pkg::TIME_W-1:0]   o_y
);

    logic                         sub;
    logic [dtt_pkg::TIME_W-1:0]   b_eff;

    assign sub   = (i_op == dtt_pkg::ALU_SUB);
    assign b_eff = sub ? ~i_b : i_b;
    assign o_y   = i_a + b_eff + dtt_pkg::TIME_W'(sub);

endmodule

[rtl/dtt_outbuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_outbuf: result output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module dtt_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtt_pkg::t_res   i_res,
    output logic            o_free,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output dtt_pkg::t_res   o_res
);

    logic          r_valid;
    dtt_pkg::t_res r_data;

    assign o_free = !r_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_data <= i_res;
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_data;

endmodule

[rtl/deadline_timer_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_table: table of one-shot timers addressed by event id
// Add, delete, expire and find commands over NUM_TIMERS slots, with a
// sequencer driving one shared adder/subtractor and a deadline RAM.
// ----------------------------------------------------------------------------
// Usage
//   Command beats arrive on i_cmd (valid/ready); result beats leave on o_res
//   (valid/ready) through an output register, so the next command is taken
//   while a final result still waits for the receiver.
//   i_cfg_we writes the lazy re-arm window at once; write it only while idle.
// Steps
//   Delete: done in the idle state. Add: deadline sum, then the lazy compare
//   against the stored deadline read from the RAM.
//   Find: a scan of all NUM_TIMERS slots, then the answer is registered.
//   Expire: a result beat per fired timer, then a done beat. Every search for
//   the earliest deadline is a scan of the RAM, one slot a cycle through the
//   shared subtractor, and is repeated after each fired timer.
// Reset clears all armed flags, the output register and restores the window
// to 300. If the receiver stalls, the sequencer holds at the next result
// beat and command ready stays low until the command is finished.
// ----------------------------------------------------------------------------
module deadline_timer_table #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  dtt_pkg::t_cmd               i_cmd,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output dtt_pkg::t_res               o_res,
    input  logic                        i_cfg_we,
    input  logic [dtt_pkg::WIN_W-1:0]   i_cfg_wdata
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int TW = dtt_pkg::TIME_W;

    dtt_pkg::t_state r_state, n_state;
    dtt_pkg::t_func  r_func, n_func;
    logic [IW-1:0]   r_slot, n_slot;
    logic            r_slot_ok, n_slot_ok;
    logic [TW-1:0]   r_now, n_now;
    logic [TW-1:0]   r_arg, n_arg;
    logic            r_canc, n_canc;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]   r_cmp_idx, n_cmp_idx;
    logic [TW-1:0]   r_best, n_best;
    logic [IW-1:0]   r_best_id, n_best_id;
    logic            r_have, n_have;
    logic [NUM_TIMERS-1:0] r_armed, n_armed;
    logic [NUM_TIMERS-1:0] r_mcan, n_mcan;
    logic [dtt_pkg::WIN_W-1:0] r_window;

    logic                cmd_acc;
    dtt_pkg::t_alu_op    alu_op;
    logic [TW-1:0]       alu_a, alu_b, alu_y;
    logic                ram_we;
    logic [IW-1:0]       ram_raddr;
    logic [TW-1:0]       ram_rdata;
    logic                out_free;
    logic                push;
    dtt_pkg::t_res       push_res;
    logic                nc_any;
    logic [15:0]         mag_hi;
    logic [16:0]         mag_lo;
    logic                in_window;

    assign o_cmd_ready = (r_state == dtt_pkg::S_IDLE);
    assign cmd_acc     = i_cmd_valid && o_cmd_ready;
    assign nc_any      = |(r_armed & ~r_mcan);

    // Magnitude of the wrap-signed difference compared with the window; a
    // negative difference d has magnitude ~d + 1.
    assign mag_hi = alu_y[TW-1] ? ~alu_y[TW-1:16] : alu_y[TW-1:16];
    assign mag_lo = alu_y[TW-1] ? ({1'b0, ~alu_y[15:0]} + 17'd1) : {1'b0, alu_y[15:0]};
    assign in_window = (mag_hi == 16'd0) && (mag_lo < {1'b0, r_window});

    dtt_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    dtt_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_TIMERS)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_arg),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dtt_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (push_res),
        .o_free      (out_free),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_slot    = r_slot;
        n_slot_ok = r_slot_ok;
        n_now     = r_now;
        n_arg     = r_arg;
        n_canc    = r_canc;
        n_cnt     = r_cnt;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_best    = r_best;
        n_best_id = r_best_id;
        n_have    = r_have;
        n_armed   = r_armed;
        n_mcan    = r_mcan;
        alu_op    = dtt_pkg::ALU_SUB;
        alu_a     = r_now;
        alu_b     = r_arg;
        ram_we    = 1'b0;
        ram_raddr = r_cnt[IW-1:0];
        push      = 1'b0;
        push_res  = '0;

        case (r_state)
            dtt_pkg::S_IDLE: begin
                if (cmd_acc) begin
                    n_func    = i_cmd.func;
                    n_slot    = IW'(i_cmd.event_id);
                    n_slot_ok = (32'(i_cmd.event_id) < NUM_TIMERS);
                    n_now     = i_cmd.now_msec;
                    n_arg     = i_cmd.delay;
                    n_canc    = i_cmd.cancelable;
                    n_cnt     = '0;
                    n_cmp_vld = 1'b0;
                    n_have    = 1'b0;
                    case (i_cmd.func)
                        dtt_pkg::FUNC_ADD: begin
                            n_state = dtt_pkg::S_KEY;
                        end
                        dtt_pkg::FUNC_DELETE: begin
                            if (32'(i_cmd.event_id) < NUM_TIMERS) begin
                                n_armed[IW'(i_cmd.event_id)] = 1'b0;
                            end
                        end
                        default: begin
                            n_state = dtt_pkg::S_SCAN;
                        end
                    endcase
                end
            end
            dtt_pkg::S_KEY: begin
                alu_op    = dtt_pkg::ALU_ADD;
                n_arg     = alu_y;
                ram_raddr = r_slot;
                if (r_slot_ok) begin
                    n_mcan[r_slot] = r_canc;
                    n_state        = dtt_pkg::S_LAZY;
                end else begin
                    n_state = dtt_pkg::S_IDLE;
                end
            end
            dtt_pkg::S_LAZY: begin
                alu_a = r_arg;
                alu_b = ram_rdata;
                if (!(r_armed[r_slot] && in_window)) begin
                    ram_we          = 1'b1;
                    n_armed[r_slot] = 1'b1;
                end
                n_state = dtt_pkg::S_IDLE;
            end
            dtt_pkg::S_SCAN: begin
                // Read slot r_cnt while comparing the slot read in the previous cycle.
                alu_a     = ram_rdata;
                alu_b     = r_best;
                n_cnt     = r_cnt + CW'(1);
                n_cmp_vld = (r_cnt != CW'(NUM_TIMERS));
                n_cmp_idx = r_cnt[IW-1:0];
                if (r_cmp_vld && r_armed[r_cmp_idx] && (!r_have || alu_y[TW-1])) begin
                    n_best    = ram_rdata;
                    n_best_id = r_cmp_idx;
                    n_have    = 1'b1;
                end
                if (r_cnt == CW'(NUM_TIMERS)) begin
                    n_state = dtt_pkg::S_EVAL;
                end
            end
            dtt_pkg::S_EVAL: begin
                if (r_func == dtt_pkg::FUNC_EXPIRE) begin
                    alu_a = r_now;
                    alu_b = r_best;
                    if (!r_have || alu_y[TW-1]) begin
                        n_state = dtt_pkg::S_DONE;
                    end else if (out_free) begin
                        push               = 1'b1;
                        push_res.kind      = dtt_pkg::KIND_FIRED;
                        push_res.fired_id  = dtt_pkg::ID_W'(r_best_id);
                        n_armed[r_best_id] = 1'b0;
                        n_cnt              = '0;
                        n_cmp_vld          = 1'b0;
                        n_have             = 1'b0;
                        n_state            = dtt_pkg::S_SCAN;
                    end
                end else begin
                    alu_a = r_best;
                    alu_b = r_now;
                    if (out_free) begin
                        push                       = 1'b1;
                        push_res.kind              = dtt_pkg::KIND_FIND;
                        push_res.infinite          = !r_have;
                        push_res.noncancel_pending = nc_any;
                        push_res.last              = 1'b1;
                        if (r_have && !alu_y[TW-1]) begin
                            push_res.time_left = alu_y[dtt_pkg::LEFT_W-1:0];
                        end
                        n_state = dtt_pkg::S_IDLE;
                    end
                end
            end
            dtt_pkg::S_DONE: begin
                if (out_free) begin
                    push          = 1'b1;
                    push_res.kind = dtt_pkg::KIND_DONE;
                    push_res.last = 1'b1;
                    n_state       = dtt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dtt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dtt_pkg::S_IDLE;
            r_armed  <= '0;
            r_mcan   <= '0;
            r_window <= dtt_pkg::LAZY_WINDOW_RST;
        end else begin
            r_state <= n_state;
            r_armed <= n_armed;
            r_mcan  <= n_mcan;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_slot    <= n_slot;
        r_slot_ok <= n_slot_ok;
        r_now     <= n_now;
        r_arg     <= n_arg;
        r_canc    <= n_canc;
        r_cnt     <= n_cnt;
        r_cmp_vld <= n_cmp_vld;
        r_cmp_idx <= n_cmp_idx;
        r_best    <= n_best;
        r_best_id <= n_best_id;
        r_have    <= n_have;
    end

endmodule

[rtl/dtt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_checker: port-level checks for the deadline timer table
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module dtt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  logic                        o_cmd_ready,
    input  dtt_pkg::t_cmd               i_cmd,
    input  logic                        o_res_valid,
    input  logic                        i_res_ready,
    input  dtt_pkg::t_res               o_res
);

    // A stalled result beat must hold.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // Expire and find scan the table, so the command side must close.
    a_busy_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && o_cmd_ready &&
        (i_cmd.func == dtt_pkg::FUNC_EXPIRE || i_cmd.func == dtt_pkg::FUNC_FIND)
        |=> !o_cmd_ready)
        else $error("command ready during a table scan");

    // Only fired-timer beats are non-final.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.last == (o_res.kind != dtt_pkg::KIND_FIRED)))
        else $error("last flag does not match result kind");

    // Fields outside a find answer are zero.
    a_find_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind != dtt_pkg::KIND_FIND
        |-> o_res.time_left == '0 && !o_res.infinite && !o_res.noncancel_pending)
        else $error("find fields set on a non-find beat");

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd_valid),
    .o_cmd_ready (o_cmd_ready),
    .i_cmd       (i_cmd),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);
